FILE: hdl/gms_pkg.sv
// Shared types and constants for the grid maze shortest-path block.
`default_nettype none
package gms_pkg;

  // Item command codes
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_SROW = 2'd2;
  localparam logic [1:0] REG_SCOL = 2'd3;

  // Status codes of a result item
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_EXIT = 3'd1;
  localparam logic [2:0] ST_START   = 3'd2;
  localparam logic [2:0] ST_UNREACH = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;

  // Cell characters
  localparam logic [7:0] WALL_CH = 8'h23;
  localparam logic [7:0] EXIT_CH = 8'h6F;
  localparam logic [7:0] MARK_CH = 8'h2E;

  // Neighbor directions, in tie-break order
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_RD_WAIT, S_RESP,
    S_SCAN_RD, S_SCAN_CHK, S_CLR, S_ST_RD, S_ST_CHK,
    S_Q_RD, S_Q_WAIT, S_CD, S_N_RD, S_N_CHK,
    S_EX_RD, S_EX_CHK, S_B_TOP, S_B_RD, S_B_CHK, S_B_MOVE
  } state_t;

  localparam int unsigned OUT_DIST_W = 12;
  localparam int unsigned DIST_MAX   = 4095;

endpackage
`default_nettype wire

FILE: hdl/gms_nbr.sv
// Shared neighbor unit: steps one cell in a direction and checks the grid edge.
`default_nettype none
module gms_nbr #(
  parameter int RW = 6,
  parameter int CW = 6,
  parameter int DW = 7
) (
  input  wire logic [RW-1:0]   row,
  input  wire logic [CW-1:0]   col,
  input  wire gms_pkg::dir_t   dir,
  input  wire logic [DW-1:0]   eff_rows,
  input  wire logic [DW-1:0]   eff_cols,
  output logic      [RW-1:0]   nrow,
  output logic      [CW-1:0]   ncol,
  output logic                 ok
);
  logic [DW-1:0] rw;
  logic [DW-1:0] cw;

  always_comb begin
    rw = DW'(row);
    cw = DW'(col);
    ok = 1'b1;
    unique case (dir)
      gms_pkg::DIR_UP: begin
        ok = (row != '0);
        rw = DW'(row) - DW'(1);
      end
      gms_pkg::DIR_RIGHT: cw = DW'(col) + DW'(1);
      gms_pkg::DIR_DOWN:  rw = DW'(row) + DW'(1);
      gms_pkg::DIR_LEFT: begin
        ok = (col != '0);
        cw = DW'(col) - DW'(1);
      end
      default: ok = 1'b0;
    endcase
    if (rw >= eff_rows || cw >= eff_cols) ok = 1'b0;
    nrow = rw[RW-1:0];
    ncol = cw[CW-1:0];
  end
endmodule
`default_nettype wire

FILE: hdl/grid_maze_shortest_path.sv
// Top level: grid store, breadth-first solver sequencer and backtrack walk.
// Sequence: a write item goes straight to its result, a read item waits on the memory read first;
//   a solve runs an exit scan, a flag clear, the search over the reached cells
//   and the walk back along the path.
// Throughput: one item at a time; one memory access per port per cycle bounds the solve.
// Reset: synchronous active-low; afterwards a clearing pass over all CELLS entries
//   (4096 at default size) zeroes the reached flags while in_tready stays low.
`default_nettype none
module grid_maze_shortest_path #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [6:0]  cfg_wdata,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // cell_row[5:0], cell_col[11:6], cell_char[19:12]
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // status[2:0], out_char[10:3], distance[22:11],
                                       // reached[23]
);
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int DWR   = $clog2(MAX_ROWS + 1);
  localparam int DWC   = $clog2(MAX_COLS + 1);
  localparam int DWM   = (DWR > DWC) ? DWR : DWC;
  localparam int DW    = (DWM > 7) ? DWM : 7;       // grid size compare width
  localparam int DISTW = AW;                        // longest path is below CELLS
  localparam int XW    = (DISTW > 12) ? DISTW : 12;
  localparam int QW    = RW + CW;

  // Row-major cell address
  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    cell_addr = AW'(r * MAX_COLS) + AW'(c);
  endfunction

  gms_pkg::state_t state_r, state_nxt;

  logic [6:0] grid_rows_r, grid_rows_nxt, grid_cols_r, grid_cols_nxt;
  logic [5:0] start_row_r, start_row_nxt, start_col_r, start_col_nxt;
  logic [RW-1:0] exit_row_r, exit_row_nxt, cur_row_r, cur_row_nxt;
  logic [RW-1:0] nb_row_r, nb_row_nxt, bst_row_r, bst_row_nxt;
  logic [CW-1:0] exit_col_r, exit_col_nxt, cur_col_r, cur_col_nxt;
  logic [CW-1:0] nb_col_r, nb_col_nxt, bst_col_r, bst_col_nxt;
  logic found_r, found_nxt, any_r, any_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [AW:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [DISTW-1:0] cur_dist_r, cur_dist_nxt;
  logic [DISTW:0] best_r, best_nxt;
  gms_pkg::dir_t dir_r, dir_nxt;

  logic [2:0]  res_status_r, res_status_nxt, out_status_r;
  logic [7:0]  res_char_r, res_char_nxt, out_char_r;
  logic [11:0] res_dist_r, res_dist_nxt, out_dist_r;
  logic        res_reach_r, res_reach_nxt, out_reach_r;
  logic        out_valid_r, out_valid_nxt, out_load;

  // memories: cell characters, {reached, distance}, BFS queue of coordinates
  logic [7:0]       cell_mem [CELLS];
  logic [DISTW:0]   dist_mem [CELLS];
  logic [QW-1:0]    queue_mem [CELLS];
  logic             cm_we, dm_we, qm_we;
  logic [AW-1:0]    cm_waddr, cm_raddr, dm_waddr, dm_raddr, qm_waddr, qm_raddr;
  logic [7:0]       cm_wdata, cm_rdata_r;
  logic [DISTW:0]   dm_wdata, dm_rdata_r;
  logic [QW-1:0]    qm_wdata, qm_rdata_r;

  always_ff @(posedge clk) begin
    if (cm_we) cell_mem[cm_waddr] <= cm_wdata;
    cm_rdata_r <= cell_mem[cm_raddr];
  end
  always_ff @(posedge clk) begin
    if (dm_we) dist_mem[dm_waddr] <= dm_wdata;
    dm_rdata_r <= dist_mem[dm_raddr];
  end
  always_ff @(posedge clk) begin
    if (qm_we) queue_mem[qm_waddr] <= qm_wdata;
    qm_rdata_r <= queue_mem[qm_raddr];
  end

  // effective grid size, clamped to the array
  logic [DW-1:0] eff_rows, eff_cols;
  assign eff_rows = (DW'(grid_rows_r) > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : DW'(grid_rows_r);
  assign eff_cols = (DW'(grid_cols_r) > DW'(MAX_COLS)) ? DW'(MAX_COLS) : DW'(grid_cols_r);

  logic [5:0] in_row, in_col;
  logic [7:0] in_char;
  logic       in_oob, start_oob, in_acc;
  logic [RW-1:0] in_row_i, start_row_i;
  logic [CW-1:0] in_col_i, start_col_i;
  assign in_row      = in_tdata[5:0];
  assign in_col      = in_tdata[11:6];
  assign in_char     = in_tdata[19:12];
  assign in_row_i    = RW'(in_row);
  assign in_col_i    = CW'(in_col);
  assign start_row_i = RW'(start_row_r);
  assign start_col_i = CW'(start_col_r);
  assign in_oob      = (DW'(in_row) >= eff_rows) || (DW'(in_col) >= eff_cols);
  assign start_oob   = (DW'(start_row_r) >= eff_rows) || (DW'(start_col_r) >= eff_cols);
  assign in_tready   = (state_r == gms_pkg::S_IDLE);
  assign in_acc      = in_tvalid && in_tready;

  // one neighbor unit shared by the search and the walk back
  logic [RW-1:0] nb_row;
  logic [CW-1:0] nb_col;
  logic          nb_ok;
  gms_nbr #(.RW(RW), .CW(CW), .DW(DW)) u_nbr (
    .row(cur_row_r), .col(cur_col_r), .dir(dir_r),
    .eff_rows(eff_rows), .eff_cols(eff_cols),
    .nrow(nb_row), .ncol(nb_col), .ok(nb_ok)
  );

  logic [XW-1:0] rd_dist_x;
  logic          cell_open, nb_reached;
  assign rd_dist_x  = XW'(dm_rdata_r[DISTW-1:0]);
  assign cell_open  = (cm_rdata_r != gms_pkg::WALL_CH);
  assign nb_reached = dm_rdata_r[DISTW];

  gms_pkg::dir_t dir_inc;
  assign dir_inc = gms_pkg::dir_t'(2'(dir_r) + 2'd1);

  always_comb begin
    state_nxt      = state_r;
    grid_rows_nxt  = grid_rows_r;
    grid_cols_nxt  = grid_cols_r;
    start_row_nxt  = start_row_r;
    start_col_nxt  = start_col_r;
    exit_row_nxt   = exit_row_r;
    exit_col_nxt   = exit_col_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    nb_row_nxt     = nb_row_r;
    nb_col_nxt     = nb_col_r;
    bst_row_nxt    = bst_row_r;
    bst_col_nxt    = bst_col_r;
    found_nxt      = found_r;
    any_nxt        = any_r;
    clr_cnt_nxt    = clr_cnt_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cur_dist_nxt   = cur_dist_r;
    best_nxt       = best_r;
    dir_nxt        = dir_r;
    res_status_nxt = res_status_r;
    res_char_nxt   = res_char_r;
    res_dist_nxt   = res_dist_r;
    res_reach_nxt  = res_reach_r;
    out_load       = 1'b0;
    cm_we = 1'b0; cm_waddr = '0; cm_wdata = '0; cm_raddr = '0;
    dm_we = 1'b0; dm_waddr = '0; dm_wdata = '0; dm_raddr = '0;
    qm_we = 1'b0; qm_waddr = '0; qm_wdata = '0; qm_raddr = '0;

    if (cfg_we) begin
      unique case (cfg_addr)
        gms_pkg::REG_ROWS: grid_rows_nxt = cfg_wdata;
        gms_pkg::REG_COLS: grid_cols_nxt = cfg_wdata;
        gms_pkg::REG_SROW: start_row_nxt = cfg_wdata[5:0];
        default:           start_col_nxt = cfg_wdata[5:0];
      endcase
    end

    unique case (state_r)
      gms_pkg::S_INIT, gms_pkg::S_CLR: begin
        dm_we       = 1'b1;
        dm_waddr    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(CELLS - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = (state_r == gms_pkg::S_INIT) ? gms_pkg::S_IDLE : gms_pkg::S_ST_RD;
        end
      end
      gms_pkg::S_IDLE: begin
        if (in_acc) begin
          res_status_nxt = gms_pkg::ST_OK;
          res_char_nxt   = '0;
          res_dist_nxt   = '0;
          res_reach_nxt  = 1'b0;
          state_nxt      = gms_pkg::S_RESP;
          unique case (in_tuser)
            gms_pkg::CMD_WRITE: begin
              if (in_oob) res_status_nxt = gms_pkg::ST_RANGE;
              else begin
                cm_we    = 1'b1;
                cm_waddr = cell_addr(in_row_i, in_col_i);
                cm_wdata = in_char;
              end
            end
            gms_pkg::CMD_READ: begin
              if (in_oob) res_status_nxt = gms_pkg::ST_RANGE;
              else begin
                cm_raddr  = cell_addr(in_row_i, in_col_i);
                dm_raddr  = cell_addr(in_row_i, in_col_i);
                state_nxt = gms_pkg::S_RD_WAIT;
              end
            end
            gms_pkg::CMD_SOLVE: begin
              if (start_oob) res_status_nxt = gms_pkg::ST_START;
              else begin
                cur_row_nxt = '0;
                cur_col_nxt = '0;
                found_nxt   = 1'b0;
                state_nxt   = gms_pkg::S_SCAN_RD;
              end
            end
            default: ;  // unused code: all-zero result
          endcase
        end
      end
      gms_pkg::S_RD_WAIT: begin
        res_char_nxt  = cm_rdata_r;
        res_reach_nxt = nb_reached;
        if (nb_reached)
          res_dist_nxt = (rd_dist_x > XW'(gms_pkg::DIST_MAX)) ? 12'hFFF : rd_dist_x[11:0];
        state_nxt = gms_pkg::S_RESP;
      end
      gms_pkg::S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = gms_pkg::S_IDLE;
        end
      end
      // exit search: last exit character in row-major order
      gms_pkg::S_SCAN_RD: begin
        cm_raddr  = cell_addr(cur_row_r, cur_col_r);
        state_nxt = gms_pkg::S_SCAN_CHK;
      end
      gms_pkg::S_SCAN_CHK: begin
        state_nxt = gms_pkg::S_SCAN_RD;
        if (cm_rdata_r == gms_pkg::EXIT_CH) begin
          found_nxt    = 1'b1;
          exit_row_nxt = cur_row_r;
          exit_col_nxt = cur_col_r;
        end
        if (DW'(cur_col_r) + DW'(1) == eff_cols) begin
          cur_col_nxt = '0;
          if (DW'(cur_row_r) + DW'(1) == eff_rows) begin
            if (found_nxt) begin
              clr_cnt_nxt = '0;
              state_nxt   = gms_pkg::S_CLR;
            end else begin
              res_status_nxt = gms_pkg::ST_NO_EXIT;
              state_nxt      = gms_pkg::S_RESP;
            end
          end else begin
            cur_row_nxt = cur_row_r + RW'(1);
          end
        end else begin
          cur_col_nxt = cur_col_r + CW'(1);
        end
      end
      // seed the search with the start cell unless it is a wall
      gms_pkg::S_ST_RD: begin
        cm_raddr  = cell_addr(start_row_i, start_col_i);
        state_nxt = gms_pkg::S_ST_CHK;
      end
      gms_pkg::S_ST_CHK: begin
        head_nxt = '0;
        tail_nxt = '0;
        if (cell_open) begin
          dm_we    = 1'b1;
          dm_waddr = cell_addr(start_row_i, start_col_i);
          dm_wdata = {1'b1, {DISTW{1'b0}}};
          qm_we    = 1'b1;
          qm_waddr = '0;
          qm_wdata = {start_row_i, start_col_i};
          tail_nxt = (AW + 1)'(1);
        end
        state_nxt = gms_pkg::S_Q_RD;
      end
      gms_pkg::S_Q_RD: begin
        if (head_r == tail_r) state_nxt = gms_pkg::S_EX_RD;
        else begin
          qm_raddr  = head_r[AW-1:0];
          head_nxt  = head_r + (AW + 1)'(1);
          state_nxt = gms_pkg::S_Q_WAIT;
        end
      end
      gms_pkg::S_Q_WAIT: begin
        cur_row_nxt = qm_rdata_r[QW-1:CW];
        cur_col_nxt = qm_rdata_r[CW-1:0];
        dm_raddr    = cell_addr(qm_rdata_r[QW-1:CW], qm_rdata_r[CW-1:0]);
        state_nxt   = gms_pkg::S_CD;
      end
      gms_pkg::S_CD: begin
        cur_dist_nxt = dm_rdata_r[DISTW-1:0];
        dir_nxt      = gms_pkg::DIR_UP;
        state_nxt    = gms_pkg::S_N_RD;
      end
      gms_pkg::S_N_RD, gms_pkg::S_B_RD: begin
        if (nb_ok) begin
          cm_raddr   = cell_addr(nb_row, nb_col);
          dm_raddr   = cell_addr(nb_row, nb_col);
          nb_row_nxt = nb_row;
          nb_col_nxt = nb_col;
          state_nxt  = (state_r == gms_pkg::S_N_RD) ? gms_pkg::S_N_CHK : gms_pkg::S_B_CHK;
        end else if (dir_r == gms_pkg::DIR_LEFT) begin
          state_nxt = (state_r == gms_pkg::S_N_RD) ? gms_pkg::S_Q_RD : gms_pkg::S_B_MOVE;
        end else begin
          dir_nxt = dir_inc;
        end
      end
      gms_pkg::S_N_CHK: begin
        if (cell_open && !nb_reached) begin
          dm_we    = 1'b1;
          dm_waddr = cell_addr(nb_row_r, nb_col_r);
          dm_wdata = {1'b1, cur_dist_r + DISTW'(1)};
          qm_we    = 1'b1;
          qm_waddr = tail_r[AW-1:0];
          qm_wdata = {nb_row_r, nb_col_r};
          tail_nxt = tail_r + (AW + 1)'(1);
        end
        if (dir_r == gms_pkg::DIR_LEFT) state_nxt = gms_pkg::S_Q_RD;
        else begin
          dir_nxt   = dir_inc;
          state_nxt = gms_pkg::S_N_RD;
        end
      end
      gms_pkg::S_EX_RD: begin
        dm_raddr  = cell_addr(exit_row_r, exit_col_r);
        state_nxt = gms_pkg::S_EX_CHK;
      end
      gms_pkg::S_EX_CHK: begin
        if (!nb_reached) begin
          res_status_nxt = gms_pkg::ST_UNREACH;
          state_nxt      = gms_pkg::S_RESP;
        end else begin
          cur_row_nxt = exit_row_r;
          cur_col_nxt = exit_col_r;
          state_nxt   = gms_pkg::S_B_TOP;
        end
      end
      // walk back: least distance, first in up/right/down/left on ties
      gms_pkg::S_B_TOP: begin
        if (cur_row_r == start_row_i && cur_col_r == start_col_i) begin
          state_nxt = gms_pkg::S_RESP;
        end else begin
          dir_nxt   = gms_pkg::DIR_UP;
          best_nxt  = '1;
          any_nxt   = 1'b0;
          state_nxt = gms_pkg::S_B_RD;
        end
      end
      gms_pkg::S_B_CHK: begin
        if (cell_open && nb_reached && ({1'b0, dm_rdata_r[DISTW-1:0]} < best_r)) begin
          best_nxt    = {1'b0, dm_rdata_r[DISTW-1:0]};
          bst_row_nxt = nb_row_r;
          bst_col_nxt = nb_col_r;
          any_nxt     = 1'b1;
        end
        if (dir_r == gms_pkg::DIR_LEFT) state_nxt = gms_pkg::S_B_MOVE;
        else begin
          dir_nxt   = dir_inc;
          state_nxt = gms_pkg::S_B_RD;
        end
      end
      gms_pkg::S_B_MOVE: begin
        if (!any_r) state_nxt = gms_pkg::S_RESP;
        else begin
          cm_we       = 1'b1;
          cm_waddr    = cell_addr(bst_row_r, bst_col_r);
          cm_wdata    = gms_pkg::MARK_CH;
          cur_row_nxt = bst_row_r;
          cur_col_nxt = bst_col_r;
          state_nxt   = gms_pkg::S_B_TOP;
        end
      end
      default: state_nxt = gms_pkg::S_IDLE;
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gms_pkg::S_INIT;
      out_valid_r <= 1'b0;
      grid_rows_r <= 7'd64;
      grid_cols_r <= 7'd64;
      start_row_r <= '0;
      start_col_r <= '0;
      exit_row_r  <= '0;
      exit_col_r  <= '0;
      clr_cnt_r   <= '0;
      found_r     <= 1'b0;
      any_r       <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      dir_r       <= gms_pkg::DIR_UP;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      grid_rows_r <= grid_rows_nxt;
      grid_cols_r <= grid_cols_nxt;
      start_row_r <= start_row_nxt;
      start_col_r <= start_col_nxt;
      exit_row_r  <= exit_row_nxt;
      exit_col_r  <= exit_col_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      found_r     <= found_nxt;
      any_r       <= any_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      dir_r       <= dir_nxt;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    cur_row_r    <= cur_row_nxt;
    cur_col_r    <= cur_col_nxt;
    nb_row_r     <= nb_row_nxt;
    nb_col_r     <= nb_col_nxt;
    bst_row_r    <= bst_row_nxt;
    bst_col_r    <= bst_col_nxt;
    cur_dist_r   <= cur_dist_nxt;
    best_r       <= best_nxt;
    res_status_r <= res_status_nxt;
    res_char_r   <= res_char_nxt;
    res_dist_r   <= res_dist_nxt;
    res_reach_r  <= res_reach_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_char_r   <= res_char_r;
      out_dist_r   <= res_dist_r;
      out_reach_r  <= res_reach_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_reach_r, out_dist_r, out_char_r, out_status_r};

endmodule
`default_nettype wire

FILE: hdl/gms_chk.sv
// Port-level checker for the grid maze block, bound to the top level.
`default_nettype none
module gms_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);
  // stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // no distance reported for an unreached cell
  a_unreached: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[23] |-> out_tdata[22:11] == 12'd0)
    else $error("distance on unreached cell");

  // an error status carries an empty payload
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != gms_pkg::ST_OK |-> out_tdata[23:3] == 21'd0)
    else $error("payload on error status");

  // status stays within the defined codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] == gms_pkg::ST_OK || out_tdata[2:0] == gms_pkg::ST_NO_EXIT
      || out_tdata[2:0] == gms_pkg::ST_START || out_tdata[2:0] == gms_pkg::ST_UNREACH
      || out_tdata[2:0] == gms_pkg::ST_RANGE))
    else $error("undefined status code");
endmodule

bind grid_maze_shortest_path gms_chk u_gms_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
